[hdl/msarf_pkg.sv]
`timescale 1ns / 1ps
package msarf_pkg;

   typedef enum logic [4:0] {
      FN_LI    = 5'd0,
      FN_ADD   = 5'd1,
      FN_ADDI  = 5'd2,
      FN_ADDU  = 5'd3,
      FN_SUB   = 5'd4,
      FN_SUBU  = 5'd5,
      FN_ADDIU = 5'd6,
      FN_MUL   = 5'd7,
      FN_MULT  = 5'd8,
      FN_DIV   = 5'd9,
      FN_AND   = 5'd10,
      FN_OR    = 5'd11,
      FN_ORI   = 5'd12,
      FN_ANDI  = 5'd13,
      FN_SLL   = 5'd14,
      FN_SRL   = 5'd15,
      FN_XOR   = 5'd16,
      FN_DUMP  = 5'd17
   } func_type;

   localparam logic [5:0] HI_INDEX = 6'd32;
   localparam logic [5:0] LO_INDEX = 6'd33;

   typedef struct packed {
      logic [4:0]  func;
      logic [4:0]  dest_index;
      logic [4:0]  src_a_index;
      logic [4:0]  src_b_index;
      logic [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic [5:0]  reg_index;
      logic [31:0] value;
      logic        last;
      logic        div_by_zero;
   } rsp_type;

   // classified command passed from front to back
   typedef enum logic [2:0] {
      CL_ALU,
      CL_MUL,
      CL_MULT,
      CL_DIV,
      CL_DUMP
   } class_type;

   typedef struct packed {
      class_type   cls;
      logic [4:0]  func;
      logic [4:0]  dest_index;
      logic [4:0]  src_a_index;
      logic [4:0]  src_b_index;
      logic [31:0] immediate;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MUL2,
      ST_DIV,
      ST_DIVFIX,
      ST_DUMP,
      ST_EMIT_LO
   } state_type;

endpackage

[hdl/msarf_front.sv]
`timescale 1ns / 1ps
module msarf_front
   import msarf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    in_ready,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);
   // two-entry queue of classified commands
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cmd;
   logic       push;

   always_comb begin
      cmd.func        = in_req.func;
      cmd.dest_index  = in_req.dest_index;
      cmd.src_a_index = in_req.src_a_index;
      cmd.src_b_index = in_req.src_b_index;
      cmd.immediate   = in_req.immediate;
      case (in_req.func)
         FN_MUL:  cmd.cls = CL_MUL;
         FN_MULT: cmd.cls = CL_MULT;
         FN_DIV:  cmd.cls = CL_DIV;
         FN_DUMP: cmd.cls = CL_DUMP;
         default: cmd.cls = CL_ALU;
      endcase
   end

   assign in_ready = (cnt_ff != 2'd2);
   // unused codes make no result: drop them here
   assign push     = in_valid && in_ready && (in_req.func <= FN_DUMP);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= cmd;
   end
endmodule

[hdl/msarf_back.sv]
`timescale 1ns / 1ps
module msarf_back
   import msarf_pkg::*;
#(
   parameter int NUM_REGS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int IW = $clog2(NUM_REGS);

   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   state_type   st_ff, st_in;
   cmd_type     c_ff, c_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] p_ff, p_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        strobe_ff, strobe_in;
   rsp_type     out_ff, out_in;
   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic [31:0] wr_val;
   logic [31:0] ra, rb, alu;
   logic [32:0] trial;
   logic [31:0] rem_sh;
   logic [47:0] pp_lo, pp_hi;
   logic [63:0] p_neg;
   // result signs captured at dispatch
   logic        sgn_ff, sgn_in, sgn_a_ff, sgn_a_in;

   function automatic logic [31:0] rd(input logic [4:0] i, input logic [31:0] v);
      rd = ({27'd0, i} < 32'(NUM_REGS)) ? v : 32'd0;
   endfunction

   assign ra = rd(q_cmd.src_a_index, regs_ff[q_cmd.src_a_index[IW-1:0]]);
   assign rb = rd(q_cmd.src_b_index, regs_ff[q_cmd.src_b_index[IW-1:0]]);

   always_comb begin
      case (q_cmd.func)
         FN_LI:                   alu = q_cmd.immediate;
         FN_ADD, FN_ADDU:         alu = ra + rb;
         FN_ADDI, FN_ADDIU:       alu = ra + q_cmd.immediate;
         FN_SUB, FN_SUBU:         alu = ra - rb;
         FN_AND:                  alu = ra & rb;
         FN_OR:                   alu = ra | rb;
         FN_ORI:                  alu = ra | q_cmd.immediate;
         FN_ANDI:                 alu = ra & q_cmd.immediate;
         FN_SLL:                  alu = ra << q_cmd.immediate[4:0];
         FN_SRL:                  alu = ra >> q_cmd.immediate[4:0];
         FN_XOR:                  alu = ra ^ rb;
         default:                 alu = 32'd0;
      endcase
   end

   // restoring divide step on magnitudes
   assign rem_sh = {rem_ff[30:0], quo_ff[31]};
   assign trial  = {1'b0, rem_sh} - {1'b0, b_ff};
   // 32x16 partial products for the 32x32 unsigned product
   assign pp_lo  = {16'd0, a_ff} * {32'd0, b_ff[15:0]};
   assign pp_hi  = {16'd0, a_ff} * {32'd0, b_ff[31:16]};
   assign p_neg  = -p_ff;

   always_comb begin
      st_in     = st_ff;
      c_in      = c_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      p_in      = p_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      q_pop     = 1'b0;
      strobe_in = 1'b0;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_idx    = q_cmd.dest_index[IW-1:0];
      wr_val    = alu;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               c_in  = q_cmd;
               a_in  = ra;
               b_in  = rb;
               case (q_cmd.cls)
                  CL_ALU: begin
                     if ({27'd0, q_cmd.dest_index} < 32'(NUM_REGS)) begin
                        wr_en     = 1'b1;
                        strobe_in = 1'b1;
                        out_in    = '{{1'b0, q_cmd.dest_index}, alu, 1'b1, 1'b0};
                     end
                  end
                  CL_MUL, CL_MULT: begin
                     if (q_cmd.cls == CL_MULT) begin
                        a_in = ra[31] ? -ra : ra;
                        b_in = rb[31] ? -rb : rb;
                     end
                     st_in = ST_MUL;
                  end
                  CL_DIV: begin
                     if (rb == 32'd0) begin
                        strobe_in = 1'b1;
                        out_in    = '{6'd0, 32'd0, 1'b1, 1'b1};
                     end else begin
                        b_in   = rb[31] ? -rb : rb;
                        quo_in = ra[31] ? -ra : ra;
                        rem_in = 32'd0;
                        cnt_in = 6'd0;
                        st_in  = ST_DIV;
                     end
                  end
                  default: begin
                     cnt_in = 6'd0;
                     st_in  = ST_DUMP;
                  end
               endcase
            end
         end
         ST_MUL: begin
            p_in  = {16'd0, pp_lo} + {pp_hi, 16'd0};
            st_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (c_ff.cls == CL_MUL) begin
               st_in = ST_IDLE;
               if ({27'd0, c_ff.dest_index} < 32'(NUM_REGS)) begin
                  wr_en     = 1'b1;
                  wr_idx    = c_ff.dest_index[IW-1:0];
                  wr_val    = p_ff[31:0];
                  strobe_in = 1'b1;
                  out_in    = '{{1'b0, c_ff.dest_index}, p_ff[31:0], 1'b1, 1'b0};
               end
            end else begin
               // sign from original operands
               if (sgn_ff) begin
                  hi_in = p_neg[63:32];
                  lo_in = p_neg[31:0];
               end else begin
                  hi_in = p_ff[63:32];
                  lo_in = p_ff[31:0];
               end
               strobe_in = 1'b1;
               out_in    = '{HI_INDEX, hi_in, 1'b0, 1'b0};
               st_in     = ST_EMIT_LO;
            end
         end
         ST_DIV: begin
            if (trial[32]) begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end else begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) st_in = ST_DIVFIX;
         end
         ST_DIVFIX: begin
            hi_in     = sgn_a_ff ? -rem_ff : rem_ff;
            lo_in     = sgn_ff ? -quo_ff : quo_ff;
            strobe_in = 1'b1;
            out_in    = '{HI_INDEX, hi_in, 1'b0, 1'b0};
            st_in     = ST_EMIT_LO;
         end
         ST_EMIT_LO: begin
            strobe_in = 1'b1;
            out_in    = '{LO_INDEX, lo_ff, 1'b1, 1'b0};
            st_in     = ST_IDLE;
         end
         ST_DUMP: begin
            strobe_in = 1'b1;
            if (cnt_ff < 6'(NUM_REGS)) begin
               out_in = '{cnt_ff, regs_ff[cnt_ff[IW-1:0]], 1'b0, 1'b0};
               cnt_in = cnt_ff + 6'd1;
            end else begin
               out_in = '{HI_INDEX, hi_ff, 1'b0, 1'b0};
               st_in  = ST_EMIT_LO;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sgn_in   = sgn_ff;
      sgn_a_in = sgn_a_ff;
      if (st_ff == ST_IDLE && q_valid) begin
         sgn_in   = ra[31] ^ rb[31];
         sgn_a_in = ra[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         strobe_ff <= 1'b0;
         hi_ff     <= 32'd0;
         lo_ff     <= 32'd0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 32'd0;
      end else begin
         st_ff     <= st_in;
         strobe_ff <= strobe_in;
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         if (wr_en) regs_ff[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      out_ff   <= out_in;
      sgn_ff   <= sgn_in;
      sgn_a_ff <= sgn_a_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = out_ff;
endmodule

[hdl/mips_subset_alu_register_file.sv]
`timescale 1ns / 1ps
// channel | ports                        | transfer
// request | start, busy, req_data        | start high while busy low
// result  | rsp_strobe, rsp_data         | every cycle rsp_strobe is high
//
// Simple ALU ops issue one per cycle while the back end is idle; each result passes the
// queue and the output register. mul: dispatch, sum of two 32x16 partial products, write.
// mult: dispatch, partial-product sum, hi, then lo. div: dispatch, 32 restoring steps,
// sign fix with hi, then lo; a zero divisor gives one flagged result. dump: dispatch,
// one register per cycle, hi, then lo. busy is high while the two-entry queue is full.
// Reset clears all registers, hi and lo at once. The receiver cannot stall.
module mips_subset_alu_register_file
   import msarf_pkg::*;
#(
   parameter int NUM_REGS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   logic    q_valid, q_pop, in_ready;
   cmd_type q_cmd;

   msarf_front u_front (
      .clock, .reset,
      .in_valid (start),
      .in_req   (req_data),
      .in_ready (in_ready),
      .q_valid, .q_cmd, .q_pop
   );

   msarf_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock, .reset,
      .q_valid, .q_cmd, .q_pop,
      .rsp_strobe, .rsp_data
   );

   assign busy = ~in_ready;
endmodule

[dv/tb_mips_subset_alu_register_file.sv]
`timescale 1ns / 1ps
// Testbench for the MIPS-subset ALU and register file.
// A local model of the registers, hi and lo predicts every result of each
// accepted command; a monitor compares each strobed result with the oldest
// prediction, field by field.
module tb_mips_subset_alu_register_file;
   import msarf_pkg::*;

   localparam int NREGS   = 32;
   localparam int MAX_ERR = 10;
   // Settle time after the last expected result: div and dump occupy the back
   // end longest, and an unused code emits nothing at all.
   localparam int DRAIN_CYCLES = 60;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Model state.
   logic [31:0] model_regs [NREGS];
   logic [31:0] model_hi;
   logic [31:0] model_lo;

   // Predicted results, oldest first.
   rsp_type expected_rsp [$];

   int mismatch_count;
   int unexpected_count;
   int rsp_count;
   int cmd_count;
   int div_zero_seen;
   int send_gap_pct;

   mips_subset_alu_register_file #(.NUM_REGS(NREGS)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

   function automatic logic [31:0] read_reg(logic [4:0] idx);
      if (idx < NREGS) return model_regs[idx];
      return 32'd0;
   endfunction

   function automatic rsp_type make_rsp(logic [5:0] idx, logic [31:0] val,
                                        logic lst, logic dz);
      rsp_type r;
      r.reg_index   = idx;
      r.value       = val;
      r.last        = lst;
      r.div_by_zero = dz;
      return r;
   endfunction

   // Append one prediction at the tail.
   task automatic queue_rsp(rsp_type r);
      expected_rsp.insert(expected_rsp.size(), r);
   endtask

   // Apply one command to the model and queue the results it causes.
   task automatic predict_cmd(req_type cmd);
      logic [31:0] a, b, imm, res, ua, ub, q, rm;
      logic [63:0] prod;
      logic        writes;
      a = read_reg(cmd.src_a_index);
      b = read_reg(cmd.src_b_index);
      imm = cmd.immediate;
      res = '0;
      writes = 1'b1;
      case (cmd.func)
         FN_LI: res = imm;
         FN_ADD, FN_ADDU: res = a + b;
         FN_ADDI, FN_ADDIU: res = a + imm;
         FN_SUB, FN_SUBU: res = a - b;
         FN_MUL: res = a * b;
         FN_AND: res = a & b;
         FN_OR: res = a | b;
         FN_ORI: res = a | imm;
         FN_ANDI: res = a & imm;
         FN_SLL: res = a << imm[4:0];
         FN_SRL: res = a >> imm[4:0];
         FN_XOR: res = a ^ b;
         FN_MULT: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            model_hi = prod[63:32];
            model_lo = prod[31:0];
            queue_rsp(make_rsp(HI_INDEX, model_hi, 1'b0, 1'b0));
            queue_rsp(make_rsp(LO_INDEX, model_lo, 1'b1, 1'b0));
            writes = 1'b0;
         end
         FN_DIV: begin
            writes = 1'b0;
            if (b == 0) begin
               queue_rsp(make_rsp(6'd0, 32'd0, 1'b1, 1'b1));
            end else begin
               ua = a[31] ? -a : a;
               ub = b[31] ? -b : b;
               q = ua / ub;
               rm = ua % ub;
               if (a[31] ^ b[31]) q = -q;
               if (a[31]) rm = -rm;
               model_lo = q;
               model_hi = rm;
               queue_rsp(make_rsp(HI_INDEX, model_hi, 1'b0, 1'b0));
               queue_rsp(make_rsp(LO_INDEX, model_lo, 1'b1, 1'b0));
            end
         end
         FN_DUMP: begin
            writes = 1'b0;
            for (int i = 0; i < NREGS; i++)
               queue_rsp(make_rsp(6'(i), model_regs[i], 1'b0, 1'b0));
            queue_rsp(make_rsp(HI_INDEX, model_hi, 1'b0, 1'b0));
            queue_rsp(make_rsp(LO_INDEX, model_lo, 1'b1, 1'b0));
         end
         default: writes = 1'b0;  // unused codes do nothing
      endcase
      if (writes && cmd.dest_index < NREGS) begin
         model_regs[cmd.dest_index] = res;
         queue_rsp(make_rsp({1'b0, cmd.dest_index}, res, 1'b1, 1'b0));
      end
   endtask

   // Send one command: optional random gap, then hold start until a transfer.
   // busy only moves at the rising edge, so it is read in the low phase.
   // start is left high on return; the next send or a drain sets it.
   task automatic send_cmd(req_type cmd);
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= cmd;
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_cmd(cmd);
      cmd_count++;
      @(negedge clock);
   endtask

   task automatic send_op(func_type f, int d, int sa, int sb, logic [31:0] imm);
      req_type c;
      c.func = f;
      c.dest_index = 5'(d);
      c.src_a_index = 5'(sa);
      c.src_b_index = 5'(sb);
      c.immediate = imm;
      send_cmd(c);
   endtask

   // Wait until every predicted result has arrived, then let the block settle.
   task automatic drain(int settle);
      int guard;
      guard = 0;
      start <= 1'b0;
      @(negedge clock);
      while (expected_rsp.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (settle) @(negedge clock);
   endtask

   // Result monitor: no back-pressure, every strobe is a transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (rsp_data.div_by_zero) div_zero_seen++;
         if (expected_rsp.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= MAX_ERR)
               $display("unexpected result idx=%0d val=%h", rsp_data.reg_index,
                        rsp_data.value);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= MAX_ERR) begin
                  $display("mismatch: exp idx=%0d val=%h last=%b dz=%b",
                           want.reg_index, want.value, want.last, want.div_by_zero);
                  $display("          got idx=%0d val=%h last=%b dz=%b",
                           rsp_data.reg_index, rsp_data.value, rsp_data.last,
                           rsp_data.div_by_zero);
               end
            end
         end
      end
   end

   // Directed: field extremes, every op, and the named corner cases.
   task automatic test_directed();
      send_op(FN_DUMP, 0, 0, 0, 0);                 // reset values
      send_op(FN_LI, 0, 0, 0, 32'h8000_0000);       // reg 0 is writable
      send_op(FN_LI, 31, 0, 0, 32'hFFFF_FFFF);
      send_op(FN_LI, 1, 0, 0, 32'h7FFF_FFFF);
      send_op(FN_ADD, 2, 1, 1, 0);                  // wraps, no trap
      send_op(FN_ADDI, 3, 1, 0, 32'd1);
      send_op(FN_ADDU, 4, 31, 31, 0);
      send_op(FN_SUB, 5, 0, 1, 0);
      send_op(FN_SUBU, 6, 1, 31, 0);
      send_op(FN_ADDIU, 7, 31, 0, 32'h8000_0000);
      send_op(FN_MUL, 8, 1, 31, 0);
      send_op(FN_MULT, 9, 0, 0, 0);                 // -2^31 squared
      send_op(FN_DIV, 0, 0, 0, 0);                  // dest ignored
      send_op(FN_LI, 10, 0, 0, 32'hFFFF_FFFF);
      send_op(FN_DIV, 0, 0, 10, 0);                 // -2^31 / -1
      send_op(FN_DIV, 0, 31, 11, 0);                // divide by zero
      send_op(FN_AND, 12, 1, 31, 0);
      send_op(FN_OR, 13, 0, 1, 0);
      send_op(FN_ORI, 14, 13, 0, 32'h5A5A_A5A5);
      send_op(FN_ANDI, 15, 31, 0, 32'hFFFF_0000);
      send_op(FN_SLL, 16, 31, 0, 32'hFFFF_FFFF);    // shift uses low 5 bits
      send_op(FN_SRL, 17, 0, 0, 32'd31);            // logical shift
      send_op(FN_XOR, 18, 1, 31, 0);
      send_op(func_type'(5'd31), 19, 1, 1, 0);      // unused code
      send_op(FN_DUMP, 31, 31, 31, 32'hFFFF_FFFF);
      drain(DRAIN_CYCLES);
   endtask

   // Random commands biased toward small ops, some div and dump.
   task automatic test_random(int count, int gap_pct);
      req_type c;
      int pick;
      send_gap_pct = gap_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         c.dest_index  = 5'($urandom);
         c.src_a_index = 5'($urandom);
         c.src_b_index = 5'($urandom);
         case ($urandom_range(3))
            0: c.immediate = $urandom;
            1: c.immediate = 32'($signed($urandom_range(16)) - 8);
            2: c.immediate = {$urandom_range(1), 31'($urandom)};
            default: c.immediate = 32'h8000_0000 ^ 32'($urandom_range(1));
         endcase
         if (pick < 3) c.func = FN_DUMP;
         else if (pick < 6) c.func = 5'($urandom_range(31, 18));
         else if (pick < 14) c.func = FN_DIV;
         else if (pick < 22) c.func = FN_LI;
         else c.func = 5'($urandom_range(16));
         send_cmd(c);
         // once mid-run, hold off until everything has drained
         if (n == count / 2) drain(0);
      end
      drain(DRAIN_CYCLES);
   endtask

   initial begin
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      mismatch_count = 0;
      unexpected_count = 0;
      rsp_count = 0;
      cmd_count = 0;
      div_zero_seen = 0;
      send_gap_pct = 0;
      for (int i = 0; i < NREGS; i++) model_regs[i] = '0;
      model_hi = '0;
      model_lo = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(142, 16);
      test_random(142, 56);
      test_random(142, 0);

      $display("covered %0d commands, %0d results checked, %0d divide-by-zero flags",
               cmd_count, rsp_count, div_zero_seen);
      $display("mismatches %0d, unexpected %0d, left over %0d",
               mismatch_count, unexpected_count, expected_rsp.size());
      if (mismatch_count == 0 && unexpected_count == 0 && expected_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
hdl/msarf_pkg.sv
hdl/msarf_front.sv
hdl/msarf_back.sv
hdl/mips_subset_alu_register_file.sv
dv/tb_mips_subset_alu_register_file.sv
